FILE: rtl/tash_pkg.sv
// Package for the two-axis stall homing unit.
// Register indexes, reset values, the degree-to-radian arithmetic and a saturating add.
// No dependencies.
package tash_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PITCH_CAL_SPEED    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROLL_CAL_SPEED     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PITCH_STALL_TORQUE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROLL_STALL_TORQUE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STALL_SPEED_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STALL_TICKS        = 3'd5;

  // Reset values of the configuration registers
  localparam logic [13:0] STALL_TORQUE_RST = 14'd10000;
  localparam logic [15:0] SPEED_LIMIT_RST  = 16'd2059;
  localparam logic [15:0] STALL_TICKS_RST  = 16'd50;

  // pi/180 in Q0.32
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Degrees Q16.16 to radians Q12.16, round half up. Result fits 28 bits signed.
  function automatic logic signed [27:0] deg_to_rad(input logic signed [31:0] deg);
    logic signed [59:0] prod;
    logic signed [59:0] rnd;
    prod = deg * $signed({1'b0, DEG_TO_RAD_Q32});
    rnd  = prod + 60'sd2147483648;
    return rnd[59:32];
  endfunction

  // Signed add of a converted angle and an offset, saturated to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [27:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] sum;
    sum = {{6{a[27]}}, a} + {{2{b[31]}}, b};
    if (sum[33] == 1'b0 && sum[32:31] != 2'b00) begin
      return 32'sh7FFF_FFFF;
    end else if (sum[33] == 1'b1 && sum[32:31] != 2'b11) begin
      return 32'sh8000_0000;
    end else begin
      return sum[31:0];
    end
  endfunction

endpackage

FILE: rtl/two_axis_stall_homing_fsm_unit.sv
// Two-axis sensorless stall homing controller, top level.
// Depends on tash_pkg.
//
// Usage: one input transfer per control tick carries enable, torque, speed and
// angle for the pitch and roll axes plus both target angles in degrees. Each
// input transfer yields exactly one result transfer with the homing flag and
// a loop mode and command per axis.
// Channels use valid/stall; a transfer happens on a clock edge with valid high
// and stall low. The item is captured in an input register and moves through
// the homing/normal update into the result register once that register can take
// it. Throughput is one item per cycle unless the receiver stalls, set by the
// single update stage (a 32x27 multiply, a saturating add and the stall compares
// per axis) that closes the state loop. When the receiver stalls, the result
// holds and the input register keeps its item; input stall rises only when the
// input register is full and cannot move. Reset (rst_ni low, asynchronous)
// empties both registers, returns the block to calibrating with both axes
// unhomed, clears counters, offsets and held commands, and loads the
// configuration reset values. The user must write configuration through
// cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle, unenforced.
module two_axis_stall_homing_fsm_unit
  import tash_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                pitch_enabled_i,
  input  logic signed [14:0]  pitch_torque_i,
  input  logic signed [31:0]  pitch_speed_i,
  input  logic signed [31:0]  pitch_angle_i,
  input  logic                roll_enabled_i,
  input  logic signed [14:0]  roll_torque_i,
  input  logic signed [31:0]  roll_speed_i,
  input  logic signed [31:0]  roll_angle_i,
  input  logic signed [31:0]  pitch_target_deg_i,
  input  logic signed [31:0]  roll_target_deg_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                homing_active_o,
  output logic                pitch_loop_mode_o,
  output logic signed [31:0]  pitch_command_o,
  output logic                roll_loop_mode_o,
  output logic signed [31:0]  roll_command_o
);

  localparam logic MODE_CAL    = 1'b0;
  localparam logic MODE_NORMAL = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [31:0] pitch_cal_speed_q, roll_cal_speed_q;
  logic [13:0]        pitch_stall_torque_q, roll_stall_torque_q;
  logic [15:0]        speed_limit_q, stall_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_cal_speed_q    <= '0;
      roll_cal_speed_q     <= '0;
      pitch_stall_torque_q <= STALL_TORQUE_RST;
      roll_stall_torque_q  <= STALL_TORQUE_RST;
      speed_limit_q        <= SPEED_LIMIT_RST;
      stall_ticks_q        <= STALL_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PITCH_CAL_SPEED:    pitch_cal_speed_q    <= cfg_data_i;
        CFG_ROLL_CAL_SPEED:     roll_cal_speed_q     <= cfg_data_i;
        CFG_PITCH_STALL_TORQUE: pitch_stall_torque_q <= cfg_data_i[13:0];
        CFG_ROLL_STALL_TORQUE:  roll_stall_torque_q  <= cfg_data_i[13:0];
        CFG_STALL_SPEED_LIMIT:  speed_limit_q        <= cfg_data_i[15:0];
        CFG_STALL_TICKS:        stall_ticks_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the update stage, result register drains
  logic in_valid_q, out_valid_q;
  logic adv, in_load;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register, no reset needed
  logic               p_en_q, r_en_q;
  logic signed [14:0] p_torque_q, r_torque_q;
  logic signed [31:0] p_speed_q, r_speed_q, p_angle_q, r_angle_q;
  logic signed [31:0] p_deg_q, r_deg_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      p_en_q     <= pitch_enabled_i;
      p_torque_q <= pitch_torque_i;
      p_speed_q  <= pitch_speed_i;
      p_angle_q  <= pitch_angle_i;
      r_en_q     <= roll_enabled_i;
      r_torque_q <= roll_torque_i;
      r_speed_q  <= roll_speed_i;
      r_angle_q  <= roll_angle_i;
      p_deg_q    <= pitch_target_deg_i;
      r_deg_q    <= roll_target_deg_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state; held modes and commands double as the result payload
  logic               mode_q, mode_d;
  logic               p_homed_q, p_homed_d, r_homed_q, r_homed_d;
  logic [15:0]        p_cnt_q, p_cnt_d, r_cnt_q, r_cnt_d;
  logic signed [31:0] p_off_q, p_off_d, r_off_q, r_off_d;
  logic               p_hmode_q, p_hmode_d, r_hmode_q, r_hmode_d;
  logic signed [31:0] p_hcmd_q, p_hcmd_d, r_hcmd_q, r_hcmd_d;

  // Stall detection per axis
  logic [15:0] p_tq_ext, r_tq_ext;
  logic [14:0] p_tq_abs, r_tq_abs;
  logic [31:0] p_sp_abs, r_sp_abs;
  logic        p_stalled, r_stalled;
  logic [15:0] p_cnt_inc, r_cnt_inc;

  assign p_tq_ext = {p_torque_q[14], p_torque_q};
  assign r_tq_ext = {r_torque_q[14], r_torque_q};
  assign p_tq_abs = p_torque_q[14] ? 15'(-p_tq_ext) : p_torque_q;
  assign r_tq_abs = r_torque_q[14] ? 15'(-r_tq_ext) : r_torque_q;
  assign p_sp_abs = p_speed_q[31] ? 32'(-p_speed_q) : p_speed_q;
  assign r_sp_abs = r_speed_q[31] ? 32'(-r_speed_q) : r_speed_q;

  assign p_stalled = (p_tq_abs >= {1'b0, pitch_stall_torque_q}) &&
                     (p_sp_abs < {16'd0, speed_limit_q});
  assign r_stalled = (r_tq_abs >= {1'b0, roll_stall_torque_q}) &&
                     (r_sp_abs < {16'd0, speed_limit_q});

  assign p_cnt_inc = (p_cnt_q != COUNT_MAX) ? p_cnt_q + 16'd1 : p_cnt_q;
  assign r_cnt_inc = (r_cnt_q != COUNT_MAX) ? r_cnt_q + 16'd1 : r_cnt_q;

  // Normal-state angle commands
  logic signed [31:0] p_norm_cmd, r_norm_cmd;
  assign p_norm_cmd = sat_add(deg_to_rad(p_deg_q), p_off_q);
  assign r_norm_cmd = sat_add(deg_to_rad(r_deg_q), r_off_q);

  // Next-state logic
  always_comb begin
    mode_d    = mode_q;
    p_homed_d = p_homed_q;
    r_homed_d = r_homed_q;
    p_cnt_d   = p_cnt_q;
    r_cnt_d   = r_cnt_q;
    p_off_d   = p_off_q;
    r_off_d   = r_off_q;
    p_hmode_d = p_hmode_q;
    r_hmode_d = r_hmode_q;
    p_hcmd_d  = p_hcmd_q;
    r_hcmd_d  = r_hcmd_q;
    unique case (mode_q)
      MODE_CAL: begin
        // pitch homing
        if (p_en_q && !p_homed_q) begin
          p_hmode_d = 1'b0;
          p_hcmd_d  = pitch_cal_speed_q;
          if (p_stalled) begin
            p_cnt_d = p_cnt_inc;
            if (p_cnt_inc >= stall_ticks_q) begin
              p_cnt_d   = '0;
              p_hmode_d = 1'b1;
              p_off_d   = p_angle_q;
              p_hcmd_d  = p_angle_q;
              p_homed_d = 1'b1;
            end
          end else begin
            p_cnt_d = '0;
          end
        end
        // roll homing
        if (r_en_q && !r_homed_q) begin
          r_hmode_d = 1'b0;
          r_hcmd_d  = roll_cal_speed_q;
          if (r_stalled) begin
            r_cnt_d = r_cnt_inc;
            if (r_cnt_inc >= stall_ticks_q) begin
              r_cnt_d   = '0;
              r_hmode_d = 1'b1;
              r_off_d   = r_angle_q;
              r_hcmd_d  = r_angle_q;
              r_homed_d = 1'b1;
            end
          end else begin
            r_cnt_d = '0;
          end
        end
        if (p_homed_d && r_homed_d) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
        p_hmode_d = 1'b1;
        r_hmode_d = 1'b1;
        p_hcmd_d  = p_norm_cmd;
        r_hcmd_d  = r_norm_cmd;
        // a dropped motor sends both axes back to homing
        if (!p_en_q || !r_en_q) begin
          mode_d    = MODE_CAL;
          p_homed_d = 1'b0;
          r_homed_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CAL;
      p_homed_q <= 1'b0;
      r_homed_q <= 1'b0;
      p_cnt_q   <= '0;
      r_cnt_q   <= '0;
      p_off_q   <= '0;
      r_off_q   <= '0;
      p_hmode_q <= 1'b0;
      r_hmode_q <= 1'b0;
      p_hcmd_q  <= '0;
      r_hcmd_q  <= '0;
    end else if (adv) begin
      mode_q    <= mode_d;
      p_homed_q <= p_homed_d;
      r_homed_q <= r_homed_d;
      p_cnt_q   <= p_cnt_d;
      r_cnt_q   <= r_cnt_d;
      p_off_q   <= p_off_d;
      r_off_q   <= r_off_d;
      p_hmode_q <= p_hmode_d;
      r_hmode_q <= r_hmode_d;
      p_hcmd_q  <= p_hcmd_d;
      r_hcmd_q  <= r_hcmd_d;
    end
  end

  // Result outputs come straight from the updated state
  assign out_valid_o       = out_valid_q;
  assign homing_active_o   = (mode_q == MODE_CAL);
  assign pitch_loop_mode_o = p_hmode_q;
  assign pitch_command_o   = p_hcmd_q;
  assign roll_loop_mode_o  = r_hmode_q;
  assign roll_command_o    = r_hcmd_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // normal operation only with both axes homed
  a_normal_homed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_NORMAL |-> (p_homed_q && r_homed_q))
    else $error("normal state without both axes homed");

  // a homed axis always holds an angle command
  a_homed_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_homed_q |-> p_hmode_q) and (r_homed_q |-> r_hmode_q))
    else $error("homed axis not in angle mode");

  // stall counters are idle outside homing
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_NORMAL |-> (p_cnt_q == '0 && r_cnt_q == '0))
    else $error("stall counter running in normal state");

  // state moves only with a transfer into the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(mode_q) && $stable(p_hcmd_q) && $stable(r_hcmd_q)))
    else $error("state changed without an item");

  // an empty input register never stalls the sender
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled while input register empty");

endmodule
